FILE: rtl/core/bgr_pkg.sv
// Package for the bitmap glyph rasterizer.
// Holds the item types, request and register codes, the controller state
// type and the command/status structs. No dependencies.
package bgr_pkg;

    // Bit of a glyph column byte that lands on the top row.
    localparam int TOP_BIT = 7;
    // Rows per glyph column are capped at one byte.
    localparam logic [3:0] MAX_ROWS = 4'd8;

    // Request codes carried in req_type.
    typedef enum logic [2:0] {
        REQ_LOAD_WIDTH  = 3'd0,
        REQ_LOAD_OFFSET = 3'd1,
        REQ_LOAD_GLYPH  = 3'd2,
        REQ_DRAW        = 3'd3,
        REQ_SEP         = 3'd4
    } t_req;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FIRST_CHAR   = 3'd0,
        CFG_CHAR_COUNT   = 3'd1,
        CFG_UNKNOWN_CHAR = 3'd2,
        CFG_GLYPH_HEIGHT = 3'd3,
        CFG_DISPLAY_COLS = 3'd4,
        CFG_ON_VALUE     = 3'd5,
        CFG_OFF_VALUE    = 3'd6,
        CFG_BASE_Y       = 3'd7
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // One input item.
    typedef struct packed {
        logic [2:0]         req_type;
        logic [10:0]        table_index;
        logic [10:0]        table_data;
        logic [7:0]         character;
        logic signed [15:0] start_x;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic               pixel_valid;
        logic [11:0]        pixel_x;
        logic [8:0]         pixel_y;
        logic [7:0]         pixel_value;
        logic               last;
        logic signed [15:0] next_x;
        logic               drew;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_COL_RD,
        S_COL_CHK,
        S_SEP_CHK,
        S_PIX,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic lookup;
        logic col_read;
        logic col_load;
        logic next_col;
        logic emit_pix;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] in_req;
        logic       col_vis;
        logic       col_last;
        logic       rows_zero;
        logic       sep_any;
        logic       row_last;
        logic       pix_last;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/bgr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the glyph tables and the glyph byte store.
module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bgr_ctrl.sv
// Controller state machine of the glyph rasterizer.
// Depends on bgr_pkg; drives the datapath through t_dp_cmd only.
module bgr_ctrl import bgr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_in_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_sts.in_req)
                        REQ_DRAW: n_state = S_LOOKUP;
                        REQ_SEP:  n_state = S_SEP_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: n_state = S_COL_RD;
            S_COL_RD: n_state = S_COL_CHK;
            S_COL_CHK: begin
                if (i_sts.col_vis && !i_sts.rows_zero) begin
                    n_state = S_PIX;
                end else if (i_sts.col_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_COL_RD;
                end
            end
            S_SEP_CHK: begin
                n_state = i_sts.sep_any ? S_PIX : S_DONE;
            end
            S_PIX: begin
                if (i_sts.out_free) begin
                    if (i_sts.pix_last) begin
                        n_state = S_IDLE;
                    end else if (i_sts.row_last) begin
                        n_state = S_COL_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.lookup     = (r_state == S_LOOKUP);
        o_cmd.col_read   = (r_state == S_COL_RD);
        o_cmd.col_load   = (r_state == S_COL_CHK);
        o_cmd.next_col   = ((r_state == S_COL_CHK) && !(i_sts.col_vis && !i_sts.rows_zero)
                            && !i_sts.col_last)
                        || ((r_state == S_PIX) && i_sts.out_free && !i_sts.pix_last
                            && i_sts.row_last);
        o_cmd.emit_pix   = (r_state == S_PIX) && i_sts.out_free;
        o_cmd.emit_empty = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

FILE: rtl/core/bgr_dp.sv
// Datapath of the glyph rasterizer: configuration registers, glyph tables,
// glyph byte store, column/row counters and the result register.
// Depends on bgr_pkg and bgr_ram.
module bgr_dp import bgr_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int GLYPH_BYTES     = 2048,
    parameter int DISPLAY_ROWS    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    localparam int GA = $clog2(GLYPH_BYTES);

    // Reduce a byte address below GLYPH_BYTES; the value stays below
    // nine times the store size, so a few constant compares suffice.
    function automatic logic [GA-1:0] f_wrap(input logic [11:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int j = 1; j <= 8; j++) begin
            if (32'(v) >= 32'(j * GLYPH_BYTES)) begin
                r = 32'(v) - 32'(j * GLYPH_BYTES);
            end
        end
        return GA'(r);
    endfunction

    // Configuration registers.
    logic [7:0]  r_first_char;
    logic [8:0]  r_char_count;
    logic [7:0]  r_unknown_char;
    logic [3:0]  r_glyph_height;
    logic [11:0] r_display_cols;
    logic [7:0]  r_on_value;
    logic [7:0]  r_off_value;
    logic [7:0]  r_base_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char   <= 8'd32;
            r_char_count   <= 9'd96;
            r_unknown_char <= 8'd63;
            r_glyph_height <= 4'd8;
            r_display_cols <= 12'd128;
            r_on_value     <= 8'd1;
            r_off_value    <= 8'd0;
            r_base_y       <= 8'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_FIRST_CHAR:   r_first_char   <= i_cfg_data[7:0];
                CFG_CHAR_COUNT:   r_char_count   <= i_cfg_data[8:0];
                CFG_UNKNOWN_CHAR: r_unknown_char <= i_cfg_data[7:0];
                CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[3:0];
                CFG_DISPLAY_COLS: r_display_cols <= i_cfg_data[11:0];
                CFG_ON_VALUE:     r_on_value     <= i_cfg_data[7:0];
                CFG_OFF_VALUE:    r_off_value    <= i_cfg_data[7:0];
                CFG_BASE_Y:       r_base_y       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Working registers of the item in progress.
    logic               r_is_sep;
    logic signed [15:0] r_sx;
    logic signed [15:0] r_next_x;
    logic signed [16:0] r_x;
    logic [2:0]         r_col;
    logic [3:0]         r_w;
    logic [10:0]        r_off;
    logic [3:0]         r_row;
    logic [7:0]         r_byte;
    logic               r_out_valid;
    t_out_item          r_out;

    // Character to glyph index mapping for the incoming item.
    logic       code_in;
    logic [7:0] code;
    logic [7:0] glyph_idx;

    assign code_in   = ({2'b0, i_in_item.character} >= {2'b0, r_first_char})
                    && ({2'b0, i_in_item.character}
                        < ({2'b0, r_first_char} + {1'b0, r_char_count}));
    assign code      = code_in ? i_in_item.character : r_unknown_char;
    assign glyph_idx = code - r_first_char;

    // Tables and glyph byte store; loads write at transfer time.
    logic [3:0]    width_rdata;
    logic [10:0]   offset_rdata;
    logic [7:0]    glyph_rdata;
    logic          is_load_w;
    logic          is_load_o;
    logic          is_load_g;

    assign is_load_w = i_cmd.accept && (i_in_item.req_type == REQ_LOAD_WIDTH);
    assign is_load_o = i_cmd.accept && (i_in_item.req_type == REQ_LOAD_OFFSET);
    assign is_load_g = i_cmd.accept && (i_in_item.req_type == REQ_LOAD_GLYPH);

    bgr_ram #(.WIDTH(4), .DEPTH(256)) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (is_load_w),
        .i_waddr (i_in_item.table_index[7:0]),
        .i_wdata (i_in_item.table_data[3:0]),
        .i_re    (i_cmd.accept),
        .i_raddr (glyph_idx),
        .o_rdata (width_rdata)
    );

    bgr_ram #(.WIDTH(11), .DEPTH(256)) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (is_load_o),
        .i_waddr (i_in_item.table_index[7:0]),
        .i_wdata (i_in_item.table_data),
        .i_re    (i_cmd.accept),
        .i_raddr (glyph_idx),
        .o_rdata (offset_rdata)
    );

    bgr_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (is_load_g),
        .i_waddr (f_wrap({1'b0, i_in_item.table_index})),
        .i_wdata (i_in_item.table_data[7:0]),
        .i_re    (i_cmd.col_read),
        .i_raddr (f_wrap({1'b0, r_off} + {9'b0, r_col})),
        .o_rdata (glyph_rdata)
    );

    // Width clamp and row count.
    logic [3:0] width_clamped;
    logic [3:0] rows;

    assign width_clamped = (width_rdata == 4'd0) ? 4'd1
                         : (width_rdata > 4'(MAX_GLYPH_WIDTH)) ? 4'(MAX_GLYPH_WIDTH)
                         : width_rdata;
    assign rows = (r_glyph_height > MAX_ROWS) ? MAX_ROWS : r_glyph_height;

    // Column and row conditions.
    logic       col_vis;
    logic       col_last;
    logic       col_final;
    logic [3:0] row_next;
    logic [9:0] row_next_abs;
    logic       row_last;
    logic [8:0] pix_y;
    logic [7:0] pix_value;

    assign col_vis   = !r_x[16] && (r_x[15:12] == 4'd0) && (r_x[11:0] < r_display_cols);
    assign col_last  = (({1'b0, r_col} + 4'd1) == r_w);
    assign col_final = r_is_sep || col_last
                    || (({1'b0, r_x[11:0]} + 13'd1) == {1'b0, r_display_cols});
    assign row_next     = r_row + 4'd1;
    assign row_next_abs = {2'b0, r_base_y} + {6'b0, row_next};
    assign row_last  = (row_next == rows)
                    || (r_is_sep && (32'(row_next_abs) >= 32'(DISPLAY_ROWS)));
    assign pix_y     = {1'b0, r_base_y} + {5'b0, r_row};
    assign pix_value = (r_is_sep || !r_byte[TOP_BIT]) ? r_off_value : r_on_value;

    // Item registers: setup at transfer, table lookup, column and row steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_sep <= (i_in_item.req_type == REQ_SEP);
            r_sx     <= i_in_item.start_x;
            r_next_x <= i_in_item.start_x + 16'sd1;
            r_x      <= {i_in_item.start_x[15], i_in_item.start_x};
            r_col    <= 3'd0;
            r_row    <= 4'd0;
        end
        if (i_cmd.lookup) begin
            r_w      <= width_clamped;
            r_off    <= offset_rdata;
            r_next_x <= r_sx + $signed({12'b0, width_clamped});
        end
        if (i_cmd.col_load) begin
            r_byte <= glyph_rdata;
            r_row  <= 4'd0;
        end
        if (i_cmd.emit_pix) begin
            r_byte <= {r_byte[6:0], 1'b0};
            r_row  <= row_next;
        end
        if (i_cmd.next_col) begin
            r_col <= r_col + 3'd1;
            r_x   <= r_x + 17'sd1;
        end
    end

    // Result register: loaded by the controller, drained by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pix || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pix) begin
            r_out.pixel_valid <= 1'b1;
            r_out.pixel_x     <= r_x[11:0];
            r_out.pixel_y     <= pix_y;
            r_out.pixel_value <= pix_value;
            r_out.last        <= row_last && col_final;
            r_out.next_x      <= (row_last && col_final) ? r_next_x : 16'sd0;
            r_out.drew        <= row_last && col_final;
        end else if (i_cmd.emit_empty) begin
            r_out.pixel_valid <= 1'b0;
            r_out.pixel_x     <= 12'd0;
            r_out.pixel_y     <= 9'd0;
            r_out.pixel_value <= 8'd0;
            r_out.last        <= 1'b1;
            r_out.next_x      <= r_next_x;
            r_out.drew        <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status to the controller.
    always_comb begin
        o_sts           = '0;
        o_sts.in_req    = i_in_item.req_type;
        o_sts.col_vis   = col_vis;
        o_sts.col_last  = col_last;
        o_sts.rows_zero = (rows == 4'd0);
        o_sts.sep_any   = col_vis && (rows != 4'd0)
                       && (32'(r_base_y) < 32'(DISPLAY_ROWS));
        o_sts.row_last  = row_last;
        o_sts.pix_last  = row_last && col_final;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

FILE: rtl/core/bitmap_glyph_rasterizer.sv
// Top level of the bitmap glyph rasterizer: controller plus datapath.
// Depends on bgr_pkg, bgr_ctrl, bgr_dp (and bgr_ram through bgr_dp).
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_ready  o_out_item (t_out_item)
// config    in         i_cfg_we (write only)      i_cfg_idx, i_cfg_data
//
// Loads write their table at transfer; the controller stays idle. A draw looks up
// the glyph, then reads and checks each column up to the last visible one and emits
// a result per pixel, or one empty final result; a separator emits a result per
// row, or one empty final result. Results leave through the single output register.
// Reset is synchronous and active low; it clears control registers and sets config defaults.
// A stalled consumer holds the controller in its pixel or final state.
module bitmap_glyph_rasterizer import bgr_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int GLYPH_BYTES     = 2048,
    parameter int DISPLAY_ROWS    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    bgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tables, counters and result register.
    bgr_dp #(
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
        .GLYPH_BYTES     (GLYPH_BYTES),
        .DISPLAY_ROWS    (DISPLAY_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/core/bgr_checker.sv
// Port-level checks on the rasterizer result channel, bound to the top level.
// Depends on bgr_pkg and bitmap_glyph_rasterizer.
module bgr_checker import bgr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A waiting result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before transfer");

    // A waiting result keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result payload changed while stalled");

    // A result without a pixel is always the final one.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.pixel_valid |-> o_out_item.last)
        else $error("empty result not marked last");

    // Cursor and drew fields are zero before the final result.
    a_mid_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> (o_out_item.next_x == 16'sd0)
                                           && !o_out_item.drew)
        else $error("next_x or drew set on a non-final result");

    // On the final result, drew matches whether it carries a pixel.
    a_drew_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> (o_out_item.drew == o_out_item.pixel_valid))
        else $error("drew disagrees with the final result");

endmodule

bind bitmap_glyph_rasterizer bgr_checker u_bgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
